>>> rtl/qoi_pkg.sv
// ----------------------------------------------------------------------------
// QOI chunk decoder package
// Item types, chunk codes and the command/status bundles shared by the
// controller, the datapath and the top level.
// ----------------------------------------------------------------------------
`default_nettype none

package qoi_pkg;

  localparam int INDEX_ENTRIES = 64;
  localparam int IDX_W         = $clog2(INDEX_ENTRIES);
  localparam int RUN_W         = 6;

  // Chunk codes
  localparam logic [7:0] OP_RGB    = 8'hFE;
  localparam logic [7:0] OP_RGBA   = 8'hFF;
  localparam logic [1:0] TAG_INDEX = 2'b00;
  localparam logic [1:0] TAG_DIFF  = 2'b01;
  localparam logic [1:0] TAG_LUMA  = 2'b10;
  localparam logic [1:0] TAG_RUN   = 2'b11;

  typedef enum logic [1:0] {
    PEND_NONE = 2'd0,
    PEND_RGB  = 2'd1,
    PEND_RGBA = 2'd2,
    PEND_LUMA = 2'd3
  } pend_op_t;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
    logic [7:0] a;
  } pixel_t;

  localparam pixel_t BLACK_PX = '{r: 8'd0, g: 8'd0, b: 8'd0, a: 8'd255};

  typedef struct packed {
    logic       frame_start;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
    logic       last_of_run;
    logic       image_done;
  } out_item_t;

  typedef struct packed {
    logic take;   // latch the incoming byte and decode it
    logic first;  // first cycle of an emission: resolve pixel, update index
    logic push;   // load one pixel into the output register
  } ctrl_cmd_t;

  typedef struct packed {
    logic emit_start;  // the presented byte produces pixels
    logic out_room;    // output register can take a pixel this cycle
    logic last_push;   // the pixel being pushed is the last of this byte
  } dp_status_t;

  // Index slot: (3r + 5g + 7b + 11a) mod 64, low bits only
  function automatic logic [IDX_W-1:0] slot_of(input pixel_t px);
    logic [IDX_W-1:0] s;
    s = px.r[IDX_W-1:0] * IDX_W'(3) + px.g[IDX_W-1:0] * IDX_W'(5)
      + px.b[IDX_W-1:0] * IDX_W'(7) + px.a[IDX_W-1:0] * IDX_W'(11);
    return s;
  endfunction

endpackage

`default_nettype wire

>>> rtl/qoi_ctrl.sv
// ----------------------------------------------------------------------------
// QOI controller
// Two-state sequencer: accept bytes while idle, then push the pixels a byte
// produces into the output register as room allows.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_stall,
  input  qoi_pkg::dp_status_t st,
  output qoi_pkg::ctrl_cmd_t  cmd
);
  import qoi_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_EMIT
  } state_t;

  state_t state;
  logic   first;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      first <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid && st.emit_start) begin
            state <= S_EMIT;
            first <= 1'b1;
          end
        end
        S_EMIT: begin
          first <= 1'b0;
          if (st.out_room && st.last_push) begin
            state <= S_IDLE;
          end
        end
      endcase
    end
  end

  always_comb begin
    in_stall  = (state != S_IDLE);
    cmd.take  = (state == S_IDLE) && in_valid;
    cmd.first = (state == S_EMIT) && first;
    cmd.push  = (state == S_EMIT) && st.out_room;
  end

endmodule

`default_nettype wire

>>> rtl/qoi_dpath.sv
// ----------------------------------------------------------------------------
// QOI datapath
// Chunk decode, pending operand bytes, previous pixel, 64-entry color index
// with per-entry valid bits, pixel counter and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_dpath (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_write,
  input  wire [31:0]          cfg_data,
  input  qoi_pkg::in_item_t   in_data,
  output qoi_pkg::out_item_t  out_data,
  output logic                out_valid,
  input  wire                 out_stall,
  input  qoi_pkg::ctrl_cmd_t  cmd,
  output qoi_pkg::dp_status_t st
);
  import qoi_pkg::*;

  // Architectural state
  logic [31:0]          pixel_total;
  pixel_t               prev;
  pend_op_t             pending;
  logic [1:0]           op_count;
  logic [23:0]          held;
  logic [31:0]          emitted;

  // Color index
  pixel_t               idx_mem [INDEX_ENTRIES];
  logic [INDEX_ENTRIES-1:0] idx_valid;
  pixel_t               idx_rd;
  logic                 idx_hit;

  // Emission
  pixel_t               px;
  logic                 use_mem;
  logic [RUN_W-1:0]     remaining;

  // Decode signals
  logic                 clr;
  logic [7:0]           byte_in;
  pixel_t               prev_e;
  pend_op_t             pend_e;
  logic [1:0]           cnt_e;
  logic [23:0]          held_e;
  logic [31:0]          emitted_e;
  logic                 complete;
  logic [1:0]           need_m1;
  pixel_t               dec_px;
  logic                 dec_emit;
  logic                 dec_mem;
  logic [RUN_W-1:0]     dec_count;
  pend_op_t             dec_pend;
  logic [1:0]           dec_cnt;
  logic [23:0]          dec_held;
  logic [7:0]           dg;
  logic [7:0]           dr;
  logic [7:0]           db;

  pixel_t               resolved;
  logic [IDX_W-1:0]     wr_slot;
  logic [31:0]          emitted_inc;
  logic                 hit_total;
  logic                 last_px;

  always_comb begin
    clr       = in_data.frame_start;
    byte_in   = in_data.data_byte;
    prev_e    = clr ? BLACK_PX  : prev;
    pend_e    = clr ? PEND_NONE : pending;
    cnt_e     = clr ? 2'd0      : op_count;
    held_e    = clr ? 24'd0     : held;
    emitted_e = clr ? 32'd0     : emitted;
    complete  = (emitted_e >= pixel_total);

    unique case (pend_e)
      PEND_RGB:  need_m1 = 2'd2;
      PEND_RGBA: need_m1 = 2'd3;
      PEND_LUMA: need_m1 = 2'd0;
      PEND_NONE: need_m1 = 2'd0;
    endcase

    dg = {2'b00, held_e[5:0]} - 8'd32;
    dr = {4'b0000, byte_in[7:4]} - 8'd8 + dg;
    db = {4'b0000, byte_in[3:0]} - 8'd8 + dg;

    dec_px    = prev_e;
    dec_emit  = 1'b0;
    dec_mem   = 1'b0;
    dec_count = RUN_W'(1);
    dec_pend  = pend_e;
    dec_cnt   = cnt_e;
    dec_held  = held_e;

    if (pend_e != PEND_NONE) begin
      if (cnt_e < need_m1) begin
        // hold another operand byte
        dec_held = {held_e[15:0], byte_in};
        dec_cnt  = cnt_e + 2'd1;
      end else begin
        dec_pend = PEND_NONE;
        dec_cnt  = 2'd0;
        dec_held = 24'd0;
        dec_emit = 1'b1;
        unique case (pend_e)
          PEND_RGB:  dec_px = '{r: held_e[15:8], g: held_e[7:0], b: byte_in, a: prev_e.a};
          PEND_RGBA: dec_px = '{r: held_e[23:16], g: held_e[15:8], b: held_e[7:0],
                                a: byte_in};
          PEND_LUMA: dec_px = '{r: prev_e.r + dr, g: prev_e.g + dg, b: prev_e.b + db,
                                a: prev_e.a};
          PEND_NONE: dec_px = prev_e;
        endcase
      end
    end else begin
      priority if (byte_in == OP_RGB) begin
        dec_pend = PEND_RGB;
      end else if (byte_in == OP_RGBA) begin
        dec_pend = PEND_RGBA;
      end else begin
        unique case (byte_in[7:6])
          TAG_INDEX: begin
            dec_emit = 1'b1;
            dec_mem  = 1'b1;
          end
          TAG_DIFF: begin
            dec_emit = 1'b1;
            dec_px   = '{r: prev_e.r + {6'd0, byte_in[5:4]} - 8'd2,
                         g: prev_e.g + {6'd0, byte_in[3:2]} - 8'd2,
                         b: prev_e.b + {6'd0, byte_in[1:0]} - 8'd2,
                         a: prev_e.a};
          end
          TAG_LUMA: begin
            dec_pend = PEND_LUMA;
            dec_held = {16'd0, byte_in};
          end
          TAG_RUN: begin
            dec_emit  = 1'b1;
            dec_count = byte_in[RUN_W-1:0] + RUN_W'(1);
          end
        endcase
      end
    end

    st.emit_start = !complete && dec_emit;

    // Emission side
    resolved    = (cmd.first && use_mem) ? (idx_hit ? idx_rd : '0) : px;
    wr_slot     = slot_of(resolved);
    emitted_inc = emitted + 32'd1;
    hit_total   = (emitted_inc == pixel_total);
    last_px     = (remaining == RUN_W'(1)) || hit_total;

    st.out_room  = !out_valid || !out_stall;
    st.last_push = last_px;
  end

  // Index memory: read on byte accept, write on the first emission cycle
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_rd <= idx_mem[byte_in[IDX_W-1:0]];
    end
    if (cmd.first) begin
      idx_mem[wr_slot] <= resolved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      idx_valid <= '0;
    end else if (cmd.take && clr) begin
      idx_valid <= '0;
    end else if (cmd.first) begin
      idx_valid[wr_slot] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      idx_hit   <= idx_valid[byte_in[IDX_W-1:0]] && !clr;
      use_mem   <= dec_mem;
      remaining <= dec_count;
    end else if (cmd.push) begin
      remaining <= remaining - RUN_W'(1);
    end
    if (cmd.take) begin
      px <= dec_px;
    end else if (cmd.first) begin
      px <= resolved;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pixel_total <= 32'd0;
      prev        <= BLACK_PX;
      pending     <= PEND_NONE;
      op_count    <= 2'd0;
      held        <= 24'd0;
      emitted     <= 32'd0;
    end else begin
      if (cfg_write) begin
        pixel_total <= cfg_data;
      end
      if (cmd.take) begin
        prev     <= prev_e;
        emitted  <= emitted_e;
        pending  <= complete ? pend_e : dec_pend;
        op_count <= complete ? cnt_e  : dec_cnt;
        held     <= complete ? held_e : dec_held;
      end
      if (cmd.first) begin
        prev <= resolved;
      end
      if (cmd.push) begin
        emitted <= emitted_inc;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.push) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      out_data.red         <= resolved.r;
      out_data.green       <= resolved.g;
      out_data.blue        <= resolved.b;
      out_data.alpha       <= resolved.a;
      out_data.last_of_run <= last_px;
      out_data.image_done  <= hit_total;
    end
  end

endmodule

`default_nettype wire

>>> rtl/qoi_chunk_decoder_top.sv
// ----------------------------------------------------------------------------
// QOI chunk decoder
// Decodes the QOI chunk stream (bytes after the header) into RGBA pixels.
// ----------------------------------------------------------------------------
// Write pixel_total (width * height) through cfg_write/cfg_data while idle.
// Feed chunk bytes on in_valid/in_stall/in_data; set frame_start on the
// first byte of an image to clear the index, previous pixel and counter.
// Pixels leave on out_valid/out_stall/out_data, with last_of_run on the
// final pixel of a byte and image_done on pixel number pixel_total.
// Opcode and operand bytes of multi-byte chunks are taken without a stall.
// Runs of up to 62 pixels go out one per cycle while the output register
// has room. The index lookup is read on the accepting edge; an index
// chunk's pixel is resolved from it in the first emission cycle.
// in_stall is high while the pixels of a byte are pushed. While out_stall
// is high on a full output register, it holds its pixel and emission waits.
// rst (synchronous) clears pixel_total, the index valid bits, the pending
// chunk state, the counter and the output valid. Once pixel_total pixels
// are out, further bytes are taken and dropped.
// ----------------------------------------------------------------------------
`default_nettype none

module qoi_chunk_decoder_top (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_write,
  input  wire [31:0]         cfg_data,
  input  wire                in_valid,
  output logic               in_stall,
  input  qoi_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  wire                out_stall,
  output qoi_pkg::out_item_t out_data
);
  import qoi_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t st;

  qoi_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .st       (st),
    .cmd      (cmd)
  );

  qoi_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .in_data   (in_data),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cmd       (cmd),
    .st        (st)
  );

endmodule

`default_nettype wire
